>>> hw/rtl/indexed_pixel_palette_expander_unit_defines.svh
// Assertion macros shared by the palette expander RTL.
`ifndef INDEXED_PIXEL_PALETTE_EXPANDER_UNIT_DEFINES_SVH
`define INDEXED_PIXEL_PALETTE_EXPANDER_UNIT_DEFINES_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define IPPE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be true outside reset.
`define IPPE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `IPPE_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define IPPE_ASSERT(label, clk, rst_n, prop, msg)
`define IPPE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

>>> hw/rtl/ippe_pkg.sv
// Types, constants and colour tables of the palette expander.
`timescale 1ns / 1ps
package ippe_pkg;

    localparam int FRAME_WIDTH     = 320;
    localparam int PALETTE_ENTRIES = 256;
    localparam int QUEUE_DEPTH     = 4;

    localparam int IDX_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int RGB_W   = 3 * CHAN_W;
    localparam int ARGB_W  = 32;
    localparam int COL_W   = 9;
    localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'hff;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  colour_index;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic              frame_start;
    } t_in_word;

    typedef struct packed {
        logic [ARGB_W-1:0] argb;
        logic              line_end;
    } t_out_word;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_q_push;

    // Dither table: two EGA colour numbers per palette index.
    localparam logic [7:0] NIBBLE_PAIRS [256] = '{
        8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 8'h88, 8'h88, 8'h78,
        8'h78, 8'h77, 8'h77, 8'h77, 8'hf7, 8'hf7, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hf7, 8'h7f, 8'h76, 8'h76, 8'h76, 8'h76,
        8'h76, 8'h86, 8'h86, 8'h86, 8'h08, 8'h08, 8'h00, 8'h00,
        8'hff, 8'hf7, 8'h77, 8'h79, 8'h99, 8'h99, 8'h91, 8'h11,
        8'h11, 8'h11, 8'h11, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00,
        8'hff, 8'hf7, 8'h77, 8'h79, 8'h79, 8'h89, 8'h89, 8'h81,
        8'h81, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hff, 8'hfe, 8'hee, 8'hee, 8'hee, 8'hee, 8'hee, 8'hee,
        8'hee, 8'hec, 8'hec, 8'hcc, 8'hcc, 8'hc4, 8'hc4, 8'hc4,
        8'hc4, 8'hc4, 8'hc4, 8'h44, 8'h44, 8'h44, 8'h44, 8'h44,
        8'h04, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hff, 8'hf7, 8'hfd, 8'h3d, 8'h3d, 8'h9d, 8'h9d, 8'h35,
        8'h95, 8'h95, 8'h15, 8'h15, 8'h15, 8'h10, 8'h00, 8'h00,
        8'hff, 8'hf7, 8'h77, 8'h77, 8'h76, 8'h76, 8'h66, 8'h66,
        8'h64, 8'h64, 8'h06, 8'h06, 8'h06, 8'h00, 8'h00, 8'h00,
        8'hff, 8'hff, 8'hfc, 8'h77, 8'hcc, 8'hcc, 8'hcc, 8'hc6,
        8'hc6, 8'h64, 8'h64, 8'h48, 8'h04, 8'h00, 8'h00, 8'h00,
        8'hff, 8'hff, 8'hfb, 8'hb7, 8'hb7, 8'hb3, 8'hb3, 8'h33,
        8'h39, 8'h39, 8'h31, 8'h90, 8'h11, 8'h01, 8'h01, 8'h00,
        8'hff, 8'hfe, 8'heb, 8'hea, 8'haa, 8'haa, 8'haa, 8'ha6,
        8'h22, 8'h26, 8'h88, 8'h88, 8'h80, 8'h00, 8'h00, 8'h00,
        8'hff, 8'hf7, 8'h77, 8'h77, 8'hc7, 8'hc6, 8'hd5, 8'hd5,
        8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hee, 8'hee, 8'hea, 8'haa, 8'haa, 8'haa, 8'ha2, 8'h22,
        8'h22, 8'h22, 8'h22, 8'h22, 8'h82, 8'h02, 8'h00, 8'h00,
        8'hff, 8'hfa, 8'hfa, 8'h7a, 8'h7a, 8'h7a, 8'h72, 8'h72,
        8'h72, 8'h82, 8'h82, 8'h88, 8'h80, 8'h00, 8'h00, 8'h00,
        8'h80, 8'h08, 8'h82, 8'h82, 8'h72, 8'h7a, 8'ha7, 8'heb,
        8'hfe, 8'h86, 8'h86, 8'h76, 8'h76, 8'h76, 8'he6, 8'hee,
        8'hff, 8'h77, 8'h77, 8'h77, 8'h76, 8'h86, 8'h06, 8'h06,
        8'h04, 8'h04, 8'h46, 8'h64, 8'h46, 8'h66, 8'h66, 8'h66
    };

    // The sixteen standard EGA colours as R:G:B.
    localparam logic [RGB_W-1:0] EGA_RGB [16] = '{
        24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
        24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
        24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
        24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
    };

endpackage

>>> hw/rtl/ippe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ippe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ippe_front.sv
// Front end: accepts words, loads the palette, tracks position and resolves colour.
`timescale 1ns / 1ps
`include "indexed_pixel_palette_expander_unit_defines.svh"
module ippe_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  ippe_pkg::t_in_word          i_data,
    output logic                        o_stall,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data,
    input  logic [ippe_pkg::QCNT_W-1:0] i_q_count,
    output ippe_pkg::t_q_push           o_push
);
    import ippe_pkg::*;

    logic              accept;
    logic              wr_acc;
    logic              pix_acc;
    logic              in_range;
    logic [PAL_AW-1:0] pal_addr;
    logic [RGB_W-1:0]  ram_rdata;
    logic [COL_W-1:0]  col_base;
    logic              par_base;
    logic              last;
    logic              odd;
    logic [7:0]        pair;
    logic [3:0]        nib;
    logic [RGB_W-1:0]  rgb;

    logic              r_ega_mode;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic              r_row;
    logic              n_row;
    logic              r_s1_valid;
    logic              r_s1_ega;
    logic              r_s1_ram;
    logic [3:0]        r_s1_nib;
    logic              r_s1_last;

    // Room is needed for the word in flight as well as the new one.
    assign o_stall = (i_q_count + QCNT_W'(r_s1_valid)) >= QCNT_W'(QUEUE_DEPTH);

    assign accept   = i_valid && !o_stall;
    assign wr_acc   = accept && (i_data.cmd == CMD_WRITE);
    assign pix_acc  = accept && (i_data.cmd == CMD_PIXEL);
    assign in_range = {1'b0, i_data.colour_index} < (IDX_W + 1)'(PALETTE_ENTRIES);
    assign pal_addr = i_data.colour_index[PAL_AW-1:0];

    ippe_ram #(
        .WIDTH(RGB_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (wr_acc && in_range),
        .i_waddr (pal_addr),
        .i_wdata ({i_data.red_in, i_data.green_in, i_data.blue_in}),
        .i_re    (pix_acc && in_range),
        .i_raddr (pal_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        col_base = i_data.frame_start ? '0 : r_col;
        par_base = i_data.frame_start ? 1'b0 : r_row;
        last     = col_base >= COL_W'(FRAME_WIDTH - 1);
        odd      = col_base[0] ^ par_base;
        pair     = NIBBLE_PAIRS[i_data.colour_index];
        nib      = odd ? pair[7:4] : pair[3:0];
        n_col    = last ? '0 : col_base + COL_W'(1);
        n_row    = last ? !par_base : par_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ega_mode <= 1'b0;
            r_col      <= '0;
            r_row      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ega_mode <= i_cfg_data;
            end
            if (pix_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_valid <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_ega  <= r_ega_mode;
            r_s1_ram  <= in_range;
            r_s1_nib  <= nib;
            r_s1_last <= last;
        end
    end

    always_comb begin
        if (r_s1_ega) begin
            rgb = EGA_RGB[r_s1_nib];
        end else if (r_s1_ram) begin
            rgb = ram_rdata;
        end else begin
            rgb = '0;
        end
        o_push.valid         = r_s1_valid;
        o_push.word.argb     = {OPAQUE_ALPHA, rgb};
        o_push.word.line_end = r_s1_last;
    end

    `IPPE_ASSERT(a_fr_pixel_staged, i_clk, i_rst_n, pix_acc |=> r_s1_valid, "pixel not staged")
    `IPPE_ASSERT(a_fr_line_wrap, i_clk, i_rst_n, (pix_acc && last) |=> (r_col == '0), "no wrap")
    `IPPE_ASSERT_NEVER(a_fr_no_push_into_full, i_clk, i_rst_n,
        r_s1_valid && (i_q_count > QCNT_W'(QUEUE_DEPTH - 1)) && !o_stall, "credit lost")

endmodule

>>> hw/rtl/ippe_queue.sv
// Result queue between the front end and the output port.
`timescale 1ns / 1ps
`include "indexed_pixel_palette_expander_unit_defines.svh"
module ippe_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ippe_pkg::t_q_push           i_push,
    input  logic                        i_stall,
    output logic                        o_valid,
    output ippe_pkg::t_out_word         o_data,
    output logic [ippe_pkg::QCNT_W-1:0] o_count
);
    import ippe_pkg::*;

    t_out_word           r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                pop;

    function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] ptr);
        next_ptr = (ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : ptr + QUEUE_AW'(1);
    endfunction

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push.valid && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push.valid && pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    `IPPE_ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n,
        i_push.valid && !pop && (r_count == QCNT_W'(QUEUE_DEPTH)), "queue overflow")
    `IPPE_ASSERT_NEVER(a_q_count_range, i_clk, i_rst_n,
        r_count > QCNT_W'(QUEUE_DEPTH), "queue count out of range")
    `IPPE_ASSERT(a_q_stalled_held, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid, "word dropped")

endmodule

>>> hw/rtl/indexed_pixel_palette_expander_unit.sv
// Top level of the indexed pixel palette expander.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake             Word
//  input     in         i_valid / o_stall     t_in_word: palette write or pixel
//  output    out        o_valid / i_stall     t_out_word: ARGB pixel, line end
//  config    in         i_cfg_valid / o_cfg_ready   ega_mode bit
//
//  One word is accepted every cycle while o_stall is low. A pixel is pushed into
//  the output queue in the cycle after acceptance, since the palette memory's read
//  data is registered, and can leave only after the queue has stored it;
//  palette writes produce no output word.
//  Reset is synchronous and clears position, EGA mode and the queue; the
//  palette contents stay undefined until written, so no clearing pass runs.
//  A stall at the output fills the four-word queue; the input stalls only
//  once the queue and the word in flight would leave no room.
//
module indexed_pixel_palette_expander_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ippe_pkg::t_in_word  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output ippe_pkg::t_out_word o_data,
    input  logic                i_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);
    import ippe_pkg::*;

    t_q_push           push;
    logic [QCNT_W-1:0] q_count;

    // Always ready, so the user must write the mode register only while idle.
    assign o_cfg_ready = 1'b1;

    // Front end: palette loads, raster position and colour selection.
    ippe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .o_stall   (o_stall),
        .i_cfg_we  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_q_count (q_count),
        .o_push    (push)
    );

    // Back end: finished pixel words wait here for the consumer.
    ippe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_count (q_count)
    );

endmodule
